// ===== hw/rtl/ptree_pkg.sv =====
// ----------------------------------------------------------------------------
// ptree_pkg
// shared widths, node record and the command and status bundles of the
// palindromic tree builder
// ----------------------------------------------------------------------------
package ptree_pkg;

    localparam int MAX_LEN      = 4096;
    localparam int ALPHABET_DEF = 26;
    localparam int NODES        = MAX_LEN + 2;

    localparam int SYM_W  = 5;
    localparam int NODE_W = 13;
    localparam int LEN_W  = 14;
    localparam int POS_W  = $clog2(MAX_LEN + 1);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELDS  = 5;
    localparam int OUT_TDATA_W = ((OUT_FIELDS * NODE_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    localparam logic [NODE_W-1:0] EVEN_ROOT  = NODE_W'(0);
    localparam logic [NODE_W-1:0] ODD_ROOT   = NODE_W'(1);
    localparam logic [NODE_W-1:0] FIRST_NODE = NODE_W'(2);

    typedef struct packed {
        logic [NODE_W-1:0]       link;
        logic signed [LEN_W-1:0] len;
        logic [NODE_W-1:0]       diff;
        logic [NODE_W-1:0]       head;
        logic [NODE_W-1:0]       parent;
        logic [SYM_W-1:0]        esym;
    } node_rec_t;

    typedef struct packed {
        logic start;
        logic drop;
        logic sym_rd;
        logic climb_next;
        logic node_load;
        logic save_cur;
        logic child_rd;
        logic child_wait;
        logic take_hit;
        logic create;
        logic out_load;
        logic link_phase;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sym_ok;
        logic full;
        logic match;
        logic hit;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== hw/rtl/ptree_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptree_ctrl
// sequencer for one symbol: suffix-link climb, child lookup, node creation
// and hand-off of the result to the output register
// ----------------------------------------------------------------------------
module ptree_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ptree_pkg::ctrl_sts_t  sts,
    output ptree_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_SYM_RD     = 8'b0000_0010,
        ST_SYM_CHK    = 8'b0000_0100,
        ST_NODE_WAIT  = 8'b0000_1000,
        ST_CHILD_RD   = 8'b0001_0000,
        ST_CHILD_WAIT = 8'b0010_0000,
        ST_CHILD_CHK  = 8'b0100_0000,
        ST_DONE       = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   phase_reg;
    logic   phase_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cmd            = '0;
        cmd.link_phase = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.sym_ok && !sts.full)
                    begin
                        cmd.start  = 1'b1;
                        phase_next = 1'b0;
                        state_next = ST_SYM_RD;
                    end
                    else
                    begin
                        cmd.drop   = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SYM_RD:
            begin
                cmd.sym_rd = 1'b1;
                state_next = ST_SYM_CHK;
            end
            ST_SYM_CHK:
            begin
                if (sts.match)
                begin
                    state_next = ST_CHILD_RD;
                end
                else
                begin
                    cmd.climb_next = 1'b1;
                    state_next     = ST_NODE_WAIT;
                end
            end
            ST_NODE_WAIT:
            begin
                cmd.node_load = 1'b1;
                state_next    = ST_SYM_RD;
            end
            ST_CHILD_RD:
            begin
                cmd.child_rd = 1'b1;
                state_next   = ST_CHILD_WAIT;
            end
            ST_CHILD_WAIT:
            begin
                cmd.child_wait = 1'b1;
                state_next     = ST_CHILD_CHK;
            end
            ST_CHILD_CHK:
            begin
                if (phase_reg)
                begin
                    cmd.create = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    // new node: climb again from the link of the extended node
                    cmd.climb_next = 1'b1;
                    cmd.save_cur   = 1'b1;
                    phase_next     = 1'b1;
                    state_next     = ST_NODE_WAIT;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== hw/rtl/ptree_dp.sv =====
// ----------------------------------------------------------------------------
// ptree_dp
// symbol, node and child memories, climb registers, node creation arithmetic
// and the output register
// ----------------------------------------------------------------------------
module ptree_dp
#(
    parameter int ALPHABET = ptree_pkg::ALPHABET_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ptree_pkg::SYM_W-1:0]    symbol,
    input  ptree_pkg::ctrl_cmd_t           cmd,
    output ptree_pkg::ctrl_sts_t           sts,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [ptree_pkg::NODE_W-1:0]   out_node,
    output logic [ptree_pkg::NODE_W-1:0]   out_len,
    output logic [ptree_pkg::NODE_W-1:0]   out_link,
    output logic [ptree_pkg::NODE_W-1:0]   out_diff,
    output logic [ptree_pkg::NODE_W-1:0]   out_head,
    output logic                           out_created,
    output logic                           out_overflow
);

    localparam int SYM_W       = ptree_pkg::SYM_W;
    localparam int NODE_W      = ptree_pkg::NODE_W;
    localparam int LEN_W       = ptree_pkg::LEN_W;
    localparam int POS_W       = ptree_pkg::POS_W;
    localparam int IDX_W       = LEN_W + 1;
    localparam int NODES       = ptree_pkg::NODES;
    localparam int CHILD_DEPTH = NODES * ALPHABET;
    localparam int CADDR_W     = $clog2(CHILD_DEPTH);

    // roots are never stored, their records are fixed
    function automatic ptree_pkg::node_rec_t root_rec(input logic odd);
        ptree_pkg::node_rec_t r;
        r        = '0;
        r.link   = odd ? ptree_pkg::EVEN_ROOT : ptree_pkg::ODD_ROOT;
        r.len    = odd ? '1 : '0;
        return r;
    endfunction

    logic [SYM_W-1:0]     sym_mem   [0:ptree_pkg::MAX_LEN];
    ptree_pkg::node_rec_t node_mem  [0:NODES-1];
    logic [NODE_W-1:0]    child_mem [0:CHILD_DEPTH-1];

    logic [SYM_W-1:0]        sym_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [NODE_W-1:0]       count_reg;
    logic [NODE_W-1:0]       last_node_reg;
    logic signed [LEN_W-1:0] last_len_reg;
    logic [NODE_W-1:0]       last_link_reg;
    logic [NODE_W-1:0]       last_diff_reg;
    logic [NODE_W-1:0]       last_head_reg;

    logic [NODE_W-1:0]       x_reg;
    logic signed [LEN_W-1:0] x_len_reg;
    logic [NODE_W-1:0]       x_link_reg;
    logic [NODE_W-1:0]       cur_reg;
    logic signed [LEN_W-1:0] cur_len_reg;
    logic [CADDR_W-1:0]      cur_addr_reg;
    logic                    idx_ok_reg;
    logic [SYM_W-1:0]        sym_rd_reg;
    logic [NODE_W-1:0]       child_rd_reg;
    logic [NODE_W-1:0]       c_reg;
    logic                    c_in_reg;
    ptree_pkg::node_rec_t    nd_raw_reg;
    logic                    nd_root_reg;
    logic                    nd_odd_reg;
    logic                    created_reg;
    logic                    overflow_reg;
    logic                    out_valid_reg;

    logic [POS_W-1:0]        pos_inc;
    logic [IDX_W-1:0]        idx;
    logic                    idx_ok;
    logic [NODE_W-1:0]       nd_addr;
    ptree_pkg::node_rec_t    nd;
    logic [CADDR_W-1:0]      child_addr;
    logic                    hit;
    logic [NODE_W-1:0]       lk_node;
    logic signed [LEN_W-1:0] lk_len;
    logic [NODE_W-1:0]       lk_diff;
    logic [NODE_W-1:0]       lk_head;
    logic signed [LEN_W-1:0] now_len;
    logic [LEN_W-1:0]        len_gap;
    logic [NODE_W-1:0]       now_diff;
    logic [NODE_W-1:0]       now_head;
    ptree_pkg::node_rec_t    new_rec;

    assign pos_inc = pos_reg + POS_W'(1);

    // mirror position: position - len - 1, valid only from slot one upward
    assign idx    = IDX_W'(pos_reg) - IDX_W'(x_len_reg) - IDX_W'(1);
    assign idx_ok = !idx[IDX_W-1] && (idx != '0);

    assign nd_addr    = cmd.child_wait ? child_rd_reg : x_link_reg;
    assign nd         = nd_root_reg ? root_rec(nd_odd_reg) : nd_raw_reg;
    assign child_addr = CADDR_W'(x_reg) * CADDR_W'(ALPHABET) + CADDR_W'(sym_reg);

    // a child entry counts only if the node it names really hangs off this edge
    assign hit = c_in_reg && (nd.parent == x_reg) && (nd.esym == sym_reg);

    assign lk_node  = hit ? c_reg : ptree_pkg::EVEN_ROOT;
    assign lk_len   = hit ? nd.len : '0;
    assign lk_diff  = hit ? nd.diff : '0;
    assign lk_head  = hit ? nd.head : '0;
    assign now_len  = cur_len_reg + LEN_W'(2);
    assign len_gap  = now_len - lk_len;
    assign now_diff = len_gap[NODE_W-1:0];
    assign now_head = (now_diff == lk_diff) ? lk_head : count_reg;

    always_comb
    begin
        new_rec        = '0;
        new_rec.link   = lk_node;
        new_rec.len    = now_len;
        new_rec.diff   = now_diff;
        new_rec.head   = now_head;
        new_rec.parent = cur_reg;
        new_rec.esym   = sym_reg;
    end

    always_comb
    begin
        sts          = '0;
        sts.sym_ok   = int'(symbol) < ALPHABET;
        sts.full     = (pos_reg >= POS_W'(ptree_pkg::MAX_LEN)) ||
                       (count_reg >= NODE_W'(NODES));
        sts.match    = (idx_ok_reg && (sym_rd_reg == sym_reg)) ||
                       (x_reg == ptree_pkg::ODD_ROOT);
        sts.hit      = hit;
        sts.out_free = !out_valid_reg || out_ready;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sym_mem[pos_inc] <= symbol;
        end
        if (cmd.sym_rd)
        begin
            sym_rd_reg <= sym_mem[idx[POS_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.create)
        begin
            node_mem[count_reg] <= new_rec;
        end
        if (cmd.climb_next || cmd.child_wait)
        begin
            nd_raw_reg <= node_mem[nd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.create)
        begin
            child_mem[cur_addr_reg] <= count_reg;
        end
        if (cmd.child_rd)
        begin
            child_rd_reg <= child_mem[child_addr];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.climb_next || cmd.child_wait)
        begin
            nd_root_reg <= nd_addr < ptree_pkg::FIRST_NODE;
            nd_odd_reg  <= nd_addr[0];
        end
        if (cmd.start)
        begin
            sym_reg    <= symbol;
            x_reg      <= last_node_reg;
            x_len_reg  <= last_len_reg;
            x_link_reg <= last_link_reg;
        end
        if (cmd.climb_next)
        begin
            x_reg <= x_link_reg;
        end
        if (cmd.node_load)
        begin
            x_len_reg  <= nd.len;
            x_link_reg <= nd.link;
        end
        if (cmd.save_cur)
        begin
            cur_reg     <= x_reg;
            cur_len_reg <= x_len_reg;
        end
        if (cmd.sym_rd)
        begin
            idx_ok_reg <= idx_ok;
        end
        if (cmd.child_rd && !cmd.link_phase)
        begin
            cur_addr_reg <= child_addr;
        end
        if (cmd.child_wait)
        begin
            c_reg    <= child_rd_reg;
            c_in_reg <= (child_rd_reg >= ptree_pkg::FIRST_NODE) &&
                        (child_rd_reg < count_reg);
        end
        if (cmd.start)
        begin
            created_reg  <= 1'b0;
            overflow_reg <= 1'b0;
        end
        if (cmd.drop)
        begin
            created_reg  <= 1'b0;
            overflow_reg <= sts.sym_ok && sts.full;
        end
        if (cmd.create)
        begin
            created_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_node     <= last_node_reg;
            out_len      <= last_len_reg[NODE_W-1:0];
            out_link     <= last_link_reg;
            out_diff     <= last_diff_reg;
            out_head     <= last_head_reg;
            out_created  <= created_reg;
            out_overflow <= overflow_reg;
        end
    end

    // tree state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= ptree_pkg::FIRST_NODE;
            last_node_reg <= ptree_pkg::EVEN_ROOT;
            last_len_reg  <= '0;
            last_link_reg <= ptree_pkg::ODD_ROOT;
            last_diff_reg <= '0;
            last_head_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                pos_reg <= pos_inc;
            end
            if (cmd.take_hit)
            begin
                last_node_reg <= c_reg;
                last_len_reg  <= nd.len;
                last_link_reg <= nd.link;
                last_diff_reg <= nd.diff;
                last_head_reg <= nd.head;
            end
            if (cmd.create)
            begin
                count_reg     <= count_reg + NODE_W'(1);
                last_node_reg <= count_reg;
                last_len_reg  <= now_len;
                last_link_reg <= lk_node;
                last_diff_reg <= now_diff;
                last_head_reg <= now_head;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/palindromic_tree_insert.sv =====
// ----------------------------------------------------------------------------
// palindromic_tree_insert
// online palindromic tree builder; one symbol in, one result out per symbol.
// s_axis carries the symbols, m_axis the node of the longest palindromic
// suffix after each symbol with its length, suffix link, length step and
// series head; tuser flags a new node and a symbol dropped on a full store.
// each suffix-link climb step costs a node-memory read and a
// symbol-memory read; creating a node takes a second climb for its link.
// one symbol is worked on at a time; the next is taken as soon as the
// result sits in the output register, even if the receiver stalls it.
// reset empties the tree to its two roots and needs no clearing pass.
// ----------------------------------------------------------------------------
module palindromic_tree_insert
#(
    parameter int ALPHABET = ptree_pkg::ALPHABET_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ptree_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // symbol
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // node_id, pal_len, suffix_node, step_diff, series_head
    output logic [ptree_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [ptree_pkg::OUT_TUSER_W-1:0]    m_axis_tuser   // created, overflow
);

    localparam int NODE_W = ptree_pkg::NODE_W;
    localparam int PAD_W  = ptree_pkg::OUT_TDATA_W - ptree_pkg::OUT_FIELDS * NODE_W;

    ptree_pkg::ctrl_cmd_t cmd;
    ptree_pkg::ctrl_sts_t sts;

    logic [NODE_W-1:0] out_node;
    logic [NODE_W-1:0] out_len;
    logic [NODE_W-1:0] out_link;
    logic [NODE_W-1:0] out_diff;
    logic [NODE_W-1:0] out_head;
    logic              out_created;
    logic              out_overflow;

    ptree_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptree_dp
    #(
        .ALPHABET (ALPHABET)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol       (s_axis_tdata[ptree_pkg::SYM_W-1:0]),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_node     (out_node),
        .out_len      (out_len),
        .out_link     (out_link),
        .out_diff     (out_diff),
        .out_head     (out_head),
        .out_created  (out_created),
        .out_overflow (out_overflow)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_head, out_diff, out_link, out_len, out_node};
    assign m_axis_tuser = {out_overflow, out_created};

`ifndef NO_ASSERTIONS
    // the input is not ready in the cycle after a transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again straight after a transfer");

    // a dropped symbol never creates a node
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_created && out_overflow))
        else $error("created and overflow both set");

    // a new node is always longer than its suffix link
    a_new_node_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_created) |-> (out_diff != '0))
        else $error("new node with zero length step");

    // nodes are only created after the second climb
    a_create_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.create |-> (cmd.link_phase && !s_axis_tready))
        else $error("node created outside the link lookup");
`endif

endmodule
